[design/clm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_pkg
// Shared types and constants of the cursor linked list manager: operation
// and status codes, controller states, payload packing and the result word.
// ----------------------------------------------------------------------------
package clm_pkg;

  // packed node payload: initial, study year, student id
  localparam int PAYLOAD_W = 28;
  localparam int ID_W      = 16;
  localparam int YEAR_W    = 4;
  localparam int INIT_W    = 8;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int NODE_OUT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_WALK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FAIL,
    S_A_WALK,
    S_A_FREE,
    S_A_LINK,
    S_I_LINK,
    S_R_LINK,
    S_W_EMIT
  } state_t;

  // one result word as held in the output register
  typedef struct packed {
    status_t               status;
    logic [NODE_OUT_W-1:0] node;
    logic [PAYLOAD_W-1:0]  payload;
    logic                  last;
  } result_t;

endpackage

[design/clm_link_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_link_mem
// Next-link store. One write and one read port, registered read data.
// Per-entry valid bits stand in for the reset chain: an entry not yet
// written reads as its own index plus one.
// ----------------------------------------------------------------------------
module clm_link_mem #(
  parameter int NODES = 8,
  parameter int IW    = 3,
  parameter int LW    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [LW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [LW-1:0] rd_data
);

  logic [LW-1:0]    mem [NODES];
  logic [NODES-1:0] vld_r;
  logic [LW-1:0]    data_r;
  logic [IW-1:0]    addr_r;
  logic             hit_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= mem[rd_addr];
      addr_r <= rd_addr;
      hit_r  <= vld_r[rd_addr];
    end
  end

  // unwritten entry reads as the reset chain
  assign rd_data = hit_r ? data_r : (LW'(addr_r) + LW'(1));

endmodule

[design/clm_data_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_data_mem
// Node payload store. One write and one read port, registered read data
// that holds until the next read. Contents are undefined until written.
// ----------------------------------------------------------------------------
module clm_data_mem #(
  parameter int NODES = 8,
  parameter int IW    = 3
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [IW-1:0]                 wr_addr,
  input  logic [clm_pkg::PAYLOAD_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [IW-1:0]                 rd_addr,
  output logic [clm_pkg::PAYLOAD_W-1:0] rd_data
);

  import clm_pkg::*;

  logic [PAYLOAD_W-1:0] mem [NODES];
  logic [PAYLOAD_W-1:0] data_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  assign rd_data = data_r;

endmodule

[design/cursor_linked_list_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_linked_list_manager
// List and free list over a pool of NODES nodes, threaded through a link
// memory, with payloads in a second memory. Append at tail, insert at head,
// remove head, and walk the list giving one word per node, for at most WALK_CAP (8) nodes.
// ----------------------------------------------------------------------------
// Sequence: insert and remove read a link, then load the result; failures load
//   a status-only word; append walks to the tail, then pops a free node and links it.
// Throughput: one word at a time; each link hop is one read of the link
//   memory port, so append and walk scale with list length.
// Reset: synchronous active-low; list empty, every node chained on the free
//   list through per-entry valid bits (no clearing pass).
module cursor_linked_list_manager #(
  parameter int NODES = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [clm_pkg::OP_W-1:0]         in_operation,
  input  logic [clm_pkg::ID_W-1:0]         in_student_id,
  input  logic [clm_pkg::YEAR_W-1:0]       in_study_year,
  input  logic [clm_pkg::INIT_W-1:0]       in_middle_initial,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [clm_pkg::STATUS_W-1:0]     out_status,
  output logic [clm_pkg::NODE_OUT_W-1:0]   out_node_index,
  output logic [clm_pkg::ID_W-1:0]         out_student_id,
  output logic [clm_pkg::YEAR_W-1:0]       out_study_year,
  output logic [clm_pkg::INIT_W-1:0]       out_initial,
  output logic                             out_last_of_run
);

  import clm_pkg::*;

  localparam int IW       = $clog2(NODES);
  localparam int LW       = $clog2(NODES + 1);
  localparam int WALK_CAP = (NODES < 8) ? NODES : 8;
  localparam int KW       = $clog2(WALK_CAP + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

  function automatic logic is_node(input logic [LW-1:0] v);
    return v < NULL_LINK;
  endfunction

  function automatic logic [NODE_OUT_W-1:0] node_out(input logic [LW-1:0] v);
    logic [IW+NODE_OUT_W-1:0] ext;
    ext = {{NODE_OUT_W{1'b0}}, v[IW-1:0]};
    return ext[NODE_OUT_W-1:0];
  endfunction

  // registers
  state_t               state_r, state_nxt;
  logic [LW-1:0]        list_head_r, list_head_nxt;
  logic [LW-1:0]        free_head_r, free_head_nxt;
  logic [LW-1:0]        cur_r, cur_nxt;
  logic [LW-1:0]        tail_r, tail_nxt;
  logic [LW-1:0]        steps_r, steps_nxt;
  logic                 pending_r, pending_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [PAYLOAD_W-1:0] pay_r, pay_nxt;
  status_t              fail_r, fail_nxt;
  result_t              out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // memory ports
  logic                 lk_wr_en, lk_rd_en;
  logic [IW-1:0]        lk_wr_addr, rd_addr;
  logic [LW-1:0]        lk_wr_data, lk_rd_data;
  logic                 dt_wr_en;
  logic [IW-1:0]        dt_wr_addr;
  logic [PAYLOAD_W-1:0] dt_rd_data;

  logic                 slot_free;
  logic [LW-1:0]        cur_w;
  logic                 walk_last;

  clm_link_mem #(.NODES(NODES), .IW(IW), .LW(LW)) u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (lk_wr_en),
    .wr_addr (lk_wr_addr),
    .wr_data (lk_wr_data),
    .rd_en   (lk_rd_en),
    .rd_addr (rd_addr),
    .rd_data (lk_rd_data)
  );

  // payload read shares the link read address and enable
  clm_data_mem #(.NODES(NODES), .IW(IW)) u_data (
    .clk     (clk),
    .wr_en   (dt_wr_en),
    .wr_addr (dt_wr_addr),
    .wr_data (pay_r),
    .rd_en   (lk_rd_en),
    .rd_addr (rd_addr),
    .rd_data (dt_rd_data)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign cur_w     = pending_r ? lk_rd_data : cur_r;
  assign walk_last = !is_node(lk_rd_data) ||
                     (({1'b0, k_r} + (KW+1)'(1)) >= (KW+1)'(WALK_CAP));

  // state register and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= NULL_LINK;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
      pending_r   <= 1'b0;
      steps_r     <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
      pending_r   <= pending_nxt;
      steps_r     <= steps_nxt;
      k_r         <= k_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    tail_r <= tail_nxt;
    pay_r  <= pay_nxt;
    fail_r <= fail_nxt;
    out_r  <= out_nxt;
  end

  // next state, memory control and result loading
  always_comb begin
    state_nxt     = state_r;
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    cur_nxt       = cur_r;
    tail_nxt      = tail_r;
    steps_nxt     = steps_r;
    pending_nxt   = 1'b0;
    k_nxt         = k_r;
    pay_nxt       = pay_r;
    fail_nxt      = fail_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    lk_wr_en      = 1'b0;
    lk_wr_addr    = free_head_r[IW-1:0];
    lk_wr_data    = NULL_LINK;
    lk_rd_en      = 1'b0;
    rd_addr       = free_head_r[IW-1:0];
    dt_wr_en      = 1'b0;
    dt_wr_addr    = free_head_r[IW-1:0];
    in_ready      = 1'b0;

    case (state_r)
      // take a word and dispatch
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pay_nxt = {in_middle_initial, in_study_year, in_student_id};
          case (op_t'(in_operation))
            OP_APPEND: begin
              if (!is_node(free_head_r)) begin
                fail_nxt  = ST_FULL;
                state_nxt = S_FAIL;
              end else begin
                cur_nxt   = list_head_r;
                tail_nxt  = NULL_LINK;
                steps_nxt = '0;
                state_nxt = S_A_WALK;
              end
            end
            OP_INSERT: begin
              if (!is_node(free_head_r)) begin
                fail_nxt  = ST_FULL;
                state_nxt = S_FAIL;
              end else begin
                lk_rd_en  = 1'b1;
                rd_addr   = free_head_r[IW-1:0];
                state_nxt = S_I_LINK;
              end
            end
            OP_REMOVE: begin
              if (!is_node(list_head_r)) begin
                fail_nxt  = ST_EMPTY;
                state_nxt = S_FAIL;
              end else begin
                lk_rd_en  = 1'b1;
                rd_addr   = list_head_r[IW-1:0];
                state_nxt = S_R_LINK;
              end
            end
            OP_WALK: begin
              if (!is_node(list_head_r)) begin
                fail_nxt  = ST_EMPTY;
                state_nxt = S_FAIL;
              end else begin
                lk_rd_en  = 1'b1;
                rd_addr   = list_head_r[IW-1:0];
                cur_nxt   = list_head_r;
                k_nxt     = '0;
                state_nxt = S_W_EMIT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // status-only result
      S_FAIL: begin
        if (slot_free) begin
          out_nxt       = '{status: fail_r, node: '0, payload: '0, last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // follow links to the tail, one hop per cycle
      S_A_WALK: begin
        if (is_node(cur_w) && (steps_r < NULL_LINK)) begin
          lk_rd_en    = 1'b1;
          rd_addr     = cur_w[IW-1:0];
          tail_nxt    = cur_w;
          steps_nxt   = steps_r + LW'(1);
          pending_nxt = 1'b1;
        end else begin
          lk_rd_en  = 1'b1;
          rd_addr   = free_head_r[IW-1:0];
          state_nxt = S_A_FREE;
        end
      end

      // pop the free node, terminate it and store the payload
      S_A_FREE: begin
        cur_nxt       = free_head_r;
        free_head_nxt = lk_rd_data;
        lk_wr_en      = 1'b1;
        lk_wr_addr    = free_head_r[IW-1:0];
        lk_wr_data    = NULL_LINK;
        dt_wr_en      = 1'b1;
        dt_wr_addr    = free_head_r[IW-1:0];
        state_nxt     = S_A_LINK;
      end

      // hook the new node behind the tail, or make it the head of an empty list
      S_A_LINK: begin
        if (slot_free) begin
          if (is_node(tail_r)) begin
            lk_wr_en   = 1'b1;
            lk_wr_addr = tail_r[IW-1:0];
            lk_wr_data = cur_r;
          end else begin
            list_head_nxt = cur_r;
          end
          out_nxt = '{status: ST_DONE, node: node_out(cur_r), payload: pay_r,
                      last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // head insert
      S_I_LINK: begin
        if (slot_free) begin
          free_head_nxt = lk_rd_data;
          list_head_nxt = free_head_r;
          lk_wr_en      = 1'b1;
          lk_wr_addr    = free_head_r[IW-1:0];
          lk_wr_data    = list_head_r;
          dt_wr_en      = 1'b1;
          dt_wr_addr    = free_head_r[IW-1:0];
          out_nxt = '{status: ST_DONE, node: node_out(free_head_r), payload: pay_r,
                      last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // head remove, node goes to the front of the free list
      S_R_LINK: begin
        if (slot_free) begin
          list_head_nxt = lk_rd_data;
          free_head_nxt = list_head_r;
          lk_wr_en      = 1'b1;
          lk_wr_addr    = list_head_r[IW-1:0];
          lk_wr_data    = free_head_r;
          out_nxt = '{status: ST_DONE, node: node_out(list_head_r),
                      payload: dt_rd_data, last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // walk: one word per node, next read issued from the link just read
      S_W_EMIT: begin
        if (slot_free) begin
          out_nxt = '{status: ST_DONE, node: node_out(cur_r), payload: dt_rd_data,
                      last: walk_last};
          out_valid_nxt = 1'b1;
          if (walk_last) begin
            state_nxt = S_IDLE;
          end else begin
            lk_rd_en = 1'b1;
            rd_addr  = lk_rd_data[IW-1:0];
            cur_nxt  = lk_rd_data;
            k_nxt    = k_r + KW'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // result ports
  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_node_index  = out_r.node;
  assign out_student_id  = out_r.payload[ID_W-1:0];
  assign out_study_year  = out_r.payload[ID_W+YEAR_W-1:ID_W];
  assign out_initial     = out_r.payload[PAYLOAD_W-1:ID_W+YEAR_W];
  assign out_last_of_run = out_r.last;

  // an accepted word always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while controller stayed idle");

  // list and free list never share a head node
  a_heads_apart: assert property (@(posedge clk) disable iff (!rst_n)
    is_node(list_head_r) && is_node(free_head_r) |-> list_head_r != free_head_r)
    else $error("list head and free head collide");

  // heads hold a node or null, nothing beyond
  a_heads_range: assert property (@(posedge clk) disable iff (!rst_n)
    list_head_r <= NULL_LINK && free_head_r <= NULL_LINK)
    else $error("head pointer out of range");

  // failure words are single and carry no node
  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_node_index == '0 && out_last_of_run)
    else $error("malformed failure word");

endmodule
